### rtl/running_percentile_two_heap_defines.svh
// Assertion macros used by the running percentile top level.
// No dependencies.
`ifndef RUNNING_PERCENTILE_TWO_HEAP_DEFINES_SVH
`define RUNNING_PERCENTILE_TWO_HEAP_DEFINES_SVH

// Implication checked at every clock edge, disabled while in reset.
`define RPTH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define RPTH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rpth_pkg.sv
// Package for the running percentile block: shared types and command codes.
// No dependencies.
`timescale 1ns / 1ps

package rpth_pkg;

  // Operation broadcast along the cell chain.
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_INS   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_INS   = 2'd1,
    ST_BAL   = 2'd2,
    ST_OUT   = 2'd3
  } state_e;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

endpackage

### rtl/running_percentile_two_heap.sv
// Running percentile block, top level: control sequencer and result register.
// Depends on rpth_pkg, rpth_chain, rpth_cell and the assertion macro header.
//
// Use: items enter on req_valid_i/req_ready_o (req_type_i, sample_i); results
// leave on res_valid_o/res_ready_i. percentile_fraction_i with
// percentile_fraction_we_i writes the Q0.16 fraction (reset 0.5); the user
// must write it only while idle; the block does not enforce this. Samples
// are kept in a sorted row of CAPACITY cells; an insert shifts all cells in
// parallel. lo_q is the size of the lower part of the row; it grows when a
// sample lands in it, and balancing then moves it by at most one per add
// toward floor(count*fraction)+1. The result is the cell at rank lo_q-1,
// read from a shift line stepped one cell per cycle: res_valid_o rises in
// the output state, reached through the insert and balance states; a dropped
// sample or a clear skips the insert state. One item at a time: req_ready_o
// is high only in the idle state, entered on the edge that takes the result.
// A result stays in the output register until taken; a stalled receiver holds
// the block. Reset empties the row at once (cell flags) and sets fraction 0.5.
`timescale 1ns / 1ps
`include "running_percentile_two_heap_defines.svh"

module running_percentile_two_heap import rpth_pkg::*; #(
  parameter int CAPACITY     = 256,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  output logic                           req_ready_o,
  input  logic                           req_type_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           percentile_fraction_we_i,
  input  logic [15:0]                    percentile_fraction_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] percentile_value_o,
  output logic                           valid_res_o,
  output logic [8:0]                     sample_count_o,
  output logic                           overflow_o
);

  localparam int CW = $clog2(CAPACITY + 1);

  state_e state_q, state_d;
  logic [15:0]                    frac_q;
  logic [CW-1:0]                  cnt_q, cnt_d;
  logic [CW-1:0]                  lo_q, lo_d;
  logic [CW-1:0]                  rank_q, rank_d;
  logic                           ovf_q, ovf_d;
  logic signed [SAMPLE_WIDTH-1:0] samp_q, samp_d;
  logic                           rvalid_q, rvalid_d;
  logic signed [SAMPLE_WIDTH-1:0] pv_q, pv_d;
  op_e                            op;
  logic                           load;
  logic signed [SAMPLE_WIDTH-1:0] head;
  logic [CW+15:0]                 prod_q;
  logic [CW-1:0]                  tgt;

  rpth_chain #(.CAPACITY(CAPACITY), .SAMPLE_WIDTH(SAMPLE_WIDTH), .CW(CW)) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .new_i       (samp_q),
    .step_i      (rank_q),
    .step_load_i (load),
    .head_o      (head)
  );

  assign req_ready_o = (state_q == ST_IDLE);

  // target size of the lower part for the current count
  assign tgt = prod_q[CW+15:16] + 1'b1;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    lo_d     = lo_q;
    rank_d   = rank_q;
    ovf_d    = ovf_q;
    samp_d   = samp_q;
    rvalid_d = rvalid_q;
    pv_d     = pv_q;
    op       = OP_NONE;
    load     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          samp_d = sample_i;
          ovf_d  = 1'b0;
          if (req_type_i == REQ_CLEAR) begin
            op      = OP_CLEAR;
            cnt_d   = '0;
            lo_d    = '0;
            state_d = ST_BAL;
          end else if (cnt_q == CW'(CAPACITY)) begin
            ovf_d   = 1'b1;
            state_d = ST_BAL;
          end else begin
            state_d = ST_INS;
          end
        end
      end
      ST_INS: begin
        op      = OP_INS;
        cnt_d   = cnt_q + 1'b1;
        // pv_q still holds the current top of the lower part
        if (lo_q == '0 || samp_q <= pv_q) begin
          lo_d = lo_q + 1'b1;
        end
        state_d = ST_BAL;
      end
      ST_BAL: begin
        // product registered below; move one sample across, then read its rank
        load = 1'b1;
        if (!ovf_q) begin
          if (lo_q > tgt) begin
            lo_d = lo_q - 1'b1;
          end else if (lo_q < tgt && cnt_q != lo_q) begin
            lo_d = lo_q + 1'b1;
          end
        end
        rank_d  = (lo_d == '0) ? '0 : lo_d - 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (rank_q != '0) begin
          rank_d = rank_q - 1'b1;
        end else if (!rvalid_q) begin
          pv_d     = (cnt_q == '0) ? '0 : head;
          rvalid_d = 1'b1;
        end else if (res_ready_i) begin
          rvalid_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      frac_q   <= 16'd32768;
      cnt_q    <= '0;
      lo_q     <= '0;
      rank_q   <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      lo_q     <= lo_d;
      rank_q   <= rank_d;
      rvalid_q <= rvalid_d;
      if (percentile_fraction_we_i) begin
        frac_q <= percentile_fraction_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q  <= ovf_d;
    samp_q <= samp_d;
    pv_q   <= pv_d;
    prod_q <= cnt_d * frac_q;
  end

  assign res_valid_o        = rvalid_q;
  assign percentile_value_o = pv_q;
  assign valid_res_o        = (cnt_q != '0);
  assign sample_count_o     = 9'(cnt_q);
  assign overflow_o         = ovf_q;

  `RPTH_ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CW'(CAPACITY), "count beyond capacity")
  `RPTH_ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, res_valid_o, !req_ready_o, "ready while result pending")
  `RPTH_ASSERT_NEXT(a_ovf_full, clk_i, rst_ni, req_valid_i && req_ready_o && req_type_i == REQ_ADD && cnt_q == CW'(CAPACITY), overflow_o, "drop not flagged")
  `RPTH_ASSERT_IMPL(a_empty_zero, clk_i, rst_ni, res_valid_o && !valid_res_o, percentile_value_o == '0, "empty value nonzero")

endmodule

### rtl/rpth_cell.sv
// One cell of the sorted chain: holds one sample and its occupied flag.
// Depends on rpth_pkg.
`timescale 1ns / 1ps

module rpth_cell import rpth_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  op_e                            op_i,
  input  logic signed [SAMPLE_WIDTH-1:0] new_i,
  // left neighbor (smaller side)
  input  logic signed [SAMPLE_WIDTH-1:0] left_val_i,
  input  logic                           left_occ_i,
  input  logic                           left_take_i,
  output logic signed [SAMPLE_WIDTH-1:0] val_o,
  output logic                           occ_o,
  output logic                           take_o
);

  logic signed [SAMPLE_WIDTH-1:0] val_q, val_d;
  logic                           occ_q, occ_d;

  // Chain kept sorted ascending: a new sample lands before the first larger cell.
  assign take_o = occ_q ? (new_i < val_q) : 1'b1;

  always_comb begin
    val_d = val_q;
    occ_d = occ_q;
    case (op_i)
      OP_INS: begin
        if (left_take_i) begin
          // shift right: neighbor moves in; past the end of the row nothing moves
          if (left_occ_i) begin
            val_d = left_val_i;
            occ_d = 1'b1;
          end
        end else if (take_o) begin
          val_d = new_i;
          occ_d = 1'b1;
        end
      end
      OP_CLEAR: occ_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign occ_o = occ_q;

endmodule

### rtl/rpth_chain.sv
// Row of sorted cells plus the readout of the cell at a given rank.
// Depends on rpth_pkg and rpth_cell.
`timescale 1ns / 1ps

module rpth_chain import rpth_pkg::*; #(
  parameter int CAPACITY     = 256,
  parameter int SAMPLE_WIDTH = 16,
  parameter int CW           = $clog2(CAPACITY + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  op_e                            op_i,
  input  logic signed [SAMPLE_WIDTH-1:0] new_i,
  input  logic [CW-1:0]                  step_i,
  input  logic                           step_load_i,
  output logic signed [SAMPLE_WIDTH-1:0] head_o
);

  logic signed [SAMPLE_WIDTH-1:0] val   [CAPACITY];
  logic                           occ   [CAPACITY];
  logic                           take  [CAPACITY];
  logic signed [SAMPLE_WIDTH-1:0] rd_q  [CAPACITY];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    rpth_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op_i),
      .new_i       (new_i),
      .left_val_i  ((g == 0) ? '0 : val[(g == 0) ? 0 : g-1]),
      .left_occ_i  ((g == 0) ? 1'b0 : occ[(g == 0) ? 0 : g-1]),
      .left_take_i ((g == 0) ? 1'b0 : take[(g == 0) ? 0 : g-1]),
      .val_o       (val[g]),
      .occ_o       (occ[g]),
      .take_o      (take[g])
    );
  end

  // Readout shift line: loaded from the cells, then stepped toward cell 0
  // one place a cycle, so the rank is read at the head without a wide mux.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (step_load_i) begin
        rd_q[i] <= val[i];
      end else if (step_i != '0) begin
        rd_q[i] <= (i == CAPACITY-1) ? rd_q[i] : rd_q[(i == CAPACITY-1) ? i : i+1];
      end
    end
  end

  assign head_o = rd_q[0];

endmodule
